### rtl/core/rect_pair_overlap_detect_macros.svh
// Assertion macros shared by the blocks of the rectangle pair detector.
// Every macro samples on the rising edge of clk and is switched off during rst.
`ifndef RECT_PAIR_OVERLAP_DETECT_MACROS_SVH
`define RECT_PAIR_OVERLAP_DETECT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPOD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RPOD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/rpod_pkg.sv
package rpod_pkg;

  localparam int ID_W    = 16;
  localparam int POS_W   = 24;
  localparam int SIZE_W  = 16;
  localparam int SLACK_W = 11;
  localparam int COORD_W = 25;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } box_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    box_t            bounds;
    logic            usable;
  } entry_t;

endpackage

### rtl/core/rpod_shrink.sv
module rpod_shrink (
  input  logic signed [rpod_pkg::POS_W-1:0]   pos_x,
  input  logic signed [rpod_pkg::POS_W-1:0]   pos_y,
  input  logic        [rpod_pkg::SIZE_W-1:0]  size_w,
  input  logic        [rpod_pkg::SIZE_W-1:0]  size_h,
  input  logic signed [rpod_pkg::SLACK_W-1:0] slack,
  output rpod_pkg::box_t                      bounds,
  output logic                                usable
);
  import rpod_pkg::*;

  coord_t px;
  coord_t py;
  coord_t w;
  coord_t h;
  coord_t s;

  assign px = coord_t'(pos_x);
  assign py = coord_t'(pos_y);
  assign w  = coord_t'($signed({{(COORD_W-SIZE_W){1'b0}}, size_w}));
  assign h  = coord_t'($signed({{(COORD_W-SIZE_W){1'b0}}, size_h}));
  assign s  = coord_t'(slack);

  assign bounds.x0 = px + s;
  assign bounds.y0 = py + s;
  assign bounds.x1 = px + w - s;
  assign bounds.y1 = py + h - s;
  assign usable    = (bounds.x1 > bounds.x0) && (bounds.y1 > bounds.y0);

endmodule

### rtl/core/rpod_overlap.sv
module rpod_overlap (
  input  rpod_pkg::box_t a,
  input  rpod_pkg::box_t b,
  output logic           hit
);
  import rpod_pkg::*;

  // Strict open overlap on both axes: touching edges do not count.
  assign hit = (a.x0 < b.x1) && (b.x0 < a.x1) && (a.y0 < b.y1) && (b.y0 < a.y1);

endmodule

### rtl/core/rpod_store.sv
module rpod_store #(
  parameter int MAX_RECTS = 64,
  localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  rpod_pkg::entry_t wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output rpod_pkg::entry_t rd_data
);
  import rpod_pkg::*;

  entry_t mem [MAX_RECTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/rect_pair_overlap_detect.sv
// Rectangle pair overlap detector. Each request carries one rectangle; it is
// shrunk by the slack register on every side and then checked against the
// rectangles already stored in the batch, one stored entry per cycle unless
// the result side stalls, through a single compare unit fed by the store's
// registered read port. A request with first set starts a new batch. Each
// overlapping pair leaves as one result request, grouped by the later
// rectangle and in stored order, with last_pair set on the final one. A
// rectangle passes through the scan, flush and write states, or straight to
// write if it is compared with none, being empty after shrinking or the start
// of a batch; the input is stalled until the block is idle again. At most
// MAX_RECTS rectangles are kept and at most MAX_RECTS - 1 pairs leave per
// rectangle; the scan stops early once that many pairs are found. The
// slack register may only be written while the block is idle.
module rect_pair_overlap_detect #(
  parameter int MAX_RECTS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic signed [rpod_pkg::SLACK_W-1:0] cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                first,
  input  logic        [rpod_pkg::ID_W-1:0]    rect_id,
  input  logic signed [rpod_pkg::POS_W-1:0]   pos_x,
  input  logic signed [rpod_pkg::POS_W-1:0]   pos_y,
  input  logic        [rpod_pkg::SIZE_W-1:0]  size_w,
  input  logic        [rpod_pkg::SIZE_W-1:0]  size_h,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic        [rpod_pkg::ID_W-1:0]    earlier_id,
  output logic        [rpod_pkg::ID_W-1:0]    later_id,
  output logic                                last_pair
);
  import rpod_pkg::*;

  `include "rect_pair_overlap_detect_macros.svh"

  localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CW = $clog2(MAX_RECTS + 1);
  localparam int HW = AW;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;
  localparam logic [1:0] S_WRITE = 2'd3;

  logic [1:0]              state;
  logic signed [SLACK_W-1:0] slack;
  logic [CW-1:0]           count;
  logic [AW-1:0]           idx;
  logic [HW-1:0]           hits;
  logic [ID_W-1:0]         cur_id;
  box_t                    cur_box;
  logic                    cur_usable;
  logic                    pend_valid;
  logic [ID_W-1:0]         pend_id;

  box_t                    new_box;
  logic                    new_usable;
  logic [CW-1:0]           count_eff;
  logic                    in_acc;
  logic                    out_free;
  logic                    hit_raw;
  logic                    hit;
  logic                    can_go;
  logic                    scan_done;
  logic                    emit;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic                    wr_en;
  entry_t                  wr_data;
  entry_t                  rd_data;

  rpod_shrink u_shrink (
    .pos_x  (pos_x),
    .pos_y  (pos_y),
    .size_w (size_w),
    .size_h (size_h),
    .slack  (slack),
    .bounds (new_box),
    .usable (new_usable)
  );

  rpod_overlap u_overlap (
    .a   (rd_data.bounds),
    .b   (cur_box),
    .hit (hit_raw)
  );

  rpod_store #(
    .MAX_RECTS (MAX_RECTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign count_eff = first ? '0 : count;
  assign out_free  = !out_valid || !out_stall;
  assign hit       = rd_data.usable && hit_raw;
  assign can_go    = !(hit && pend_valid && !out_free);
  assign scan_done = ((CW'(idx) + CW'(1)) == count) ||
                     (hit && (hits == HW'(MAX_RECTS - 2)));
  assign emit      = ((state == S_SCAN) && can_go && hit && pend_valid) ||
                     ((state == S_FLUSH) && pend_valid && out_free);

  assign wr_en   = (state == S_WRITE) && (count != CW'(MAX_RECTS));
  assign wr_data = '{id: cur_id, bounds: cur_box, usable: cur_usable};

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state)
      S_IDLE: begin
        rd_en = in_acc && new_usable && (count_eff != '0);
      end
      S_SCAN: begin
        rd_en   = can_go && !scan_done;
        rd_addr = idx + AW'(1);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slack      <= '0;
      count      <= '0;
      idx        <= '0;
      hits       <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        slack <= cfg_wr_data;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            cur_id     <= rect_id;
            cur_box    <= new_box;
            cur_usable <= new_usable;
            count      <= count_eff;
            idx        <= '0;
            hits       <= '0;
            pend_valid <= 1'b0;
            if (new_usable && (count_eff != '0)) begin
              state <= S_SCAN;
            end else begin
              state <= S_WRITE;
            end
          end
        end
        S_SCAN: begin
          if (can_go) begin
            if (hit) begin
              if (pend_valid) begin
                earlier_id <= pend_id;
                later_id   <= cur_id;
                last_pair  <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_id    <= rd_data.id;
              hits       <= hits + HW'(1);
            end
            if (scan_done) begin
              state <= S_FLUSH;
            end else begin
              idx <= idx + AW'(1);
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_WRITE;
          end else if (out_free) begin
            earlier_id <= pend_id;
            later_id   <= cur_id;
            last_pair  <= 1'b1;
            pend_valid <= 1'b0;
            state      <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (count != CW'(MAX_RECTS)) begin
            count <= count + CW'(1);
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `RPOD_ASSERT_SAME(a_scan_nonempty, state == S_SCAN, count != '0,
    "Scan running over an empty store")
  `RPOD_ASSERT_SAME(a_pend_in_scan, pend_valid, state == S_SCAN || state == S_FLUSH,
    "Pending pair held outside the scan")
  `RPOD_ASSERT_SAME(a_hits_bound, state == S_SCAN, hits < HW'(MAX_RECTS - 1),
    "Pair count exceeded its limit during the scan")
  `RPOD_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable({earlier_id, later_id, last_pair}),
    "Stalled result changed or was dropped")

endmodule
